// ===== src/sbs_pkg.sv =====
// Shared constants for the stereographic bilinear sampler: beat layout,
// opcode codes and fixed-point constants. No dependencies.
package sbs_pkg;

    // Opcode carried in s_tuser[0].
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Field widths.
    localparam int IDX_W   = 18;
    localparam int TEXEL_W = 32;
    localparam int DIR_W   = 16;
    localparam int FRAC_W  = 16;

    // Input beat layout, lowest bit first.
    localparam int IDX_LSB = 0;
    localparam int VAL_LSB = IDX_LSB + IDX_W;
    localparam int DX_LSB  = VAL_LSB + TEXEL_W;
    localparam int DY_LSB  = DX_LSB + DIR_W;
    localparam int DZ_LSB  = DY_LSB + DIR_W;
    localparam int S_PACKED_W = DZ_LSB + DIR_W;
    localparam int S_TDATA_W  = ((S_PACKED_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = 2;

    localparam int M_TDATA_W = TEXEL_W;
    localparam int M_TUSER_W = 1;

    // 1.0 in Q1.14 and in Q.16, and one half of the final Q.32 product.
    localparam logic [DIR_W-1:0]  ONE_Q14    = 16'd16384;
    localparam logic [FRAC_W:0]   ONE_Q16    = 17'h10000;
    localparam logic [64:0]       ROUND_HALF = 65'h0_8000_0000;

endpackage

// ===== src/stereographic_bilinear_sampler.sv =====
// Stereographic bilinear sampler: two hemisphere texel stores and a deep
// pipeline that projects a direction, folds, fetches and blends four texels.
// Depends on sbs_pkg.
//
// An accepted s_ beat passes the stage 0 register, the projection divider
// stages, stages A to C, the fold divider stages, stages E to I and the
// output register; each divider stage retires one quotient bit. Throughput:
// one beat per cycle, write or sample, while the skid entry is empty, set
// by the single-issue pipeline and the two replicated dual-read texel stores.
// Reset: aresetn clears all valid bits and the output buffer; texel stores
// are not cleared and hold undefined data until written.
module stereographic_bilinear_sampler #(
    parameter int MAP_SIZE = 512
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: texel_index, texel_value, dir_x, dir_y, dir_z, zero pad
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sbs_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: opcode, map_select
    input  logic [sbs_pkg::S_TUSER_W-1:0]  s_tuser,
    // m_tdata: flux
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sbs_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: upper_used
    output logic [sbs_pkg::M_TUSER_W-1:0]  m_tuser
);
    import sbs_pkg::*;

    // Geometry. D is the map radius in texels.
    localparam int D         = MAP_SIZE / 2;
    localparam int MAP_WORDS = MAP_SIZE * MAP_SIZE;
    localparam int IW        = $clog2(MAP_WORDS);
    localparam int RW        = $clog2(MAP_SIZE);
    localparam int DBW       = $clog2(D + 1);

    // Projection divider: |x|*D*2^16 / den, one quotient bit per stage.
    localparam int NBW  = DIR_W + DBW;
    localparam int NW   = NBW + FRAC_W;
    localparam int DENW = DIR_W;

    // Texel coordinates lie within [-2D, 2D+1]; a = 2X+1 within +-(4D+3).
    localparam int TXW = DBW + 3;
    localparam int AVW = TXW + 2;
    localparam int AMW = DBW + 3;
    localparam int QW  = 2 * AMW + 1;
    localparam int FQB = DBW + 1;
    localparam int CW  = QW + FQB;
    localparam int RCW = TXW + 2;
    localparam int WW  = 2 * FRAC_W + 1;

    localparam int FOLD_LIM = 4 * D * D;
    localparam int TWO_DD   = 2 * D * D;

    typedef struct packed {
        logic            smp;
        logic            up;
        logic            we;
        logic [IW:0]     waddr;
        logic [TEXEL_W-1:0] wval;
    } ctl_t;

    typedef struct packed {
        logic [DENW-1:0] den;
        logic            negx;
        logic            negy;
        logic [NW-1:0]   nx;
        logic [NW-1:0]   ny;
        logic [NW-1:0]   qx;
        logic [NW-1:0]   qy;
        logic [DENW-1:0] rx;
        logic [DENW-1:0] ry;
    } dv_t;

    typedef struct packed {
        logic [QW-1:0]  q;
        logic [CW-1:0]  rx;
        logic [CW-1:0]  ry;
        logic [FQB-1:0] qx;
        logic [FQB-1:0] qy;
        logic           sx;
        logic           sy;
        logic           fold;
        logic [TXW-1:0] tx;
        logic [TXW-1:0] ty;
        logic [WW-1:0]  w;
    } fd_t;

    // One restoring step of the projection divider.
    function automatic dv_t dv_step(dv_t d);
        dv_t             o;
        logic [DENW:0]   tx;
        logic [DENW:0]   ty;
        o  = d;
        tx = {d.rx, d.nx[NW-1]};
        ty = {d.ry, d.ny[NW-1]};
        o.nx = d.nx << 1;
        o.ny = d.ny << 1;
        if (tx >= {1'b0, d.den}) begin
            o.rx = DENW'(tx - {1'b0, d.den});
            o.qx = {d.qx[NW-2:0], 1'b1};
        end else begin
            o.rx = tx[DENW-1:0];
            o.qx = {d.qx[NW-2:0], 1'b0};
        end
        if (ty >= {1'b0, d.den}) begin
            o.ry = DENW'(ty - {1'b0, d.den});
            o.qy = {d.qy[NW-2:0], 1'b1};
        end else begin
            o.ry = ty[DENW-1:0];
            o.qy = {d.qy[NW-2:0], 1'b0};
        end
        return o;
    endfunction

    // One restoring step of a fold divider, producing quotient bit sh.
    function automatic fd_t fd_step(fd_t f, int unsigned sh);
        fd_t           o;
        logic [CW-1:0] qs;
        o  = f;
        qs = CW'(f.q) << sh;
        if (f.rx >= qs) begin
            o.rx = f.rx - qs;
            o.qx = f.qx | (FQB'(1) << sh);
        end
        if (f.ry >= qs) begin
            o.ry = f.ry - qs;
            o.qy = f.qy | (FQB'(1) << sh);
        end
        return o;
    endfunction

    // The whole pipeline moves together; it stops only while the skid
    // register holds a result, so no beat is ever dropped or repeated.
    logic adv;
    logic skid_valid_reg;
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    // ---------------------------------------------------------------
    // Input decode and stage 0 register.
    // ---------------------------------------------------------------
    logic                    in_op;
    logic                    in_msel;
    logic [IDX_W-1:0]        in_idx;
    logic [TEXEL_W-1:0]      in_val;
    logic signed [DIR_W-1:0] in_dx;
    logic signed [DIR_W-1:0] in_dy;
    logic signed [DIR_W-1:0] in_dz;
    logic [DIR_W-1:0]        abs_x;
    logic [DIR_W-1:0]        abs_y;
    logic [DIR_W-1:0]        abs_z;
    dv_t                     dv_in;
    ctl_t                    ctl_in;

    always_comb begin
        in_op   = s_tuser[0];
        in_msel = s_tuser[1];
        in_idx  = s_tdata[IDX_LSB +: IDX_W];
        in_val  = s_tdata[VAL_LSB +: TEXEL_W];
        in_dx   = s_tdata[DX_LSB +: DIR_W];
        in_dy   = s_tdata[DY_LSB +: DIR_W];
        in_dz   = s_tdata[DZ_LSB +: DIR_W];
        abs_x   = in_dx[DIR_W-1] ? DIR_W'(-in_dx) : DIR_W'(in_dx);
        abs_y   = in_dy[DIR_W-1] ? DIR_W'(-in_dy) : DIR_W'(in_dy);
        abs_z   = in_dz[DIR_W-1] ? DIR_W'(-in_dz) : DIR_W'(in_dz);

        // Whichever hemisphere is chosen, 1 - z becomes 1 + |z|.
        dv_in.den  = ONE_Q14 + abs_z;
        dv_in.negx = in_dx[DIR_W-1];
        dv_in.negy = in_dy[DIR_W-1];
        dv_in.nx   = {NBW'(abs_x) * NBW'(D), {FRAC_W{1'b0}}};
        dv_in.ny   = {NBW'(abs_y) * NBW'(D), {FRAC_W{1'b0}}};
        dv_in.qx   = '0;
        dv_in.qy   = '0;
        dv_in.rx   = '0;
        dv_in.ry   = '0;

        ctl_in.smp   = (in_op == OP_SAMPLE);
        ctl_in.up    = !in_dz[DIR_W-1] && (in_dz != '0);
        ctl_in.we    = (in_op == OP_WRITE) && (32'(in_idx) < 32'(MAP_WORDS));
        ctl_in.waddr = {in_msel, IW'(in_idx)};
        ctl_in.wval  = in_val;
    end

    logic dv_vld_reg [NW+1];
    dv_t  dv_reg     [NW+1];
    ctl_t dv_ctl_reg [NW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_vld_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_reg[0]     <= dv_in;
            dv_ctl_reg[0] <= ctl_in;
        end
    end

    // ---------------------------------------------------------------
    // Projection divider stages.
    // ---------------------------------------------------------------
    for (genvar k = 0; k < NW; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_reg[k+1]     <= dv_step(dv_reg[k]);
                dv_ctl_reg[k+1] <= dv_ctl_reg[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage A: floor the quotients, split into cell and fraction.
    // ---------------------------------------------------------------
    logic [NW:0]   xm;
    logic [NW:0]   ym;
    logic [NW:0]   xc;
    logic [NW:0]   yc;

    always_comb begin
        xm = {1'b0, dv_reg[NW].qx} + (NW+1)'(dv_reg[NW].negx && dv_reg[NW].rx != '0);
        ym = {1'b0, dv_reg[NW].qy} + (NW+1)'(dv_reg[NW].negy && dv_reg[NW].ry != '0);
        xc = dv_reg[NW].negx ? -xm : xm;
        yc = dv_reg[NW].negy ? -ym : ym;
    end

    logic                  a_vld_reg;
    ctl_t                  a_ctl_reg;
    logic signed [TXW-1:0] a_x1_reg;
    logic signed [TXW-1:0] a_y1_reg;
    logic [FRAC_W-1:0]     a_fx_reg;
    logic [FRAC_W-1:0]     a_fy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (adv) begin
            a_vld_reg <= dv_vld_reg[NW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_ctl_reg <= dv_ctl_reg[NW];
            a_x1_reg  <= xc[FRAC_W +: TXW];
            a_y1_reg  <= yc[FRAC_W +: TXW];
            a_fx_reg  <= xc[FRAC_W-1:0];
            a_fy_reg  <= yc[FRAC_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage B: neighbor coordinates, squares of 2X+1, bilinear weights.
    // Index 0 is the floor cell, index 1 the next one.
    // ---------------------------------------------------------------
    logic signed [TXW-1:0] b_tx_next [2];
    logic signed [TXW-1:0] b_ty_next [2];
    logic signed [AVW-1:0] av [2];
    logic signed [AVW-1:0] bv [2];
    logic [AMW-1:0]        b_amag_next [2];
    logic [AMW-1:0]        b_bmag_next [2];
    logic [FRAC_W:0]       wx [2];
    logic [FRAC_W:0]       wy [2];
    logic [WW-1:0]         b_w_next [4];

    always_comb begin
        b_tx_next[0] = a_x1_reg;
        b_tx_next[1] = a_x1_reg + TXW'(1);
        b_ty_next[0] = a_y1_reg;
        b_ty_next[1] = a_y1_reg + TXW'(1);
        for (int i = 0; i < 2; i++) begin
            av[i] = {(AVW-1)'(b_tx_next[i]), 1'b1};
            bv[i] = {(AVW-1)'(b_ty_next[i]), 1'b1};
            b_amag_next[i] = av[i][AVW-1] ? AMW'(-av[i]) : AMW'(av[i]);
            b_bmag_next[i] = bv[i][AVW-1] ? AMW'(-bv[i]) : AMW'(bv[i]);
        end
        wx[0] = ONE_Q16 - {1'b0, a_fx_reg};
        wx[1] = {1'b0, a_fx_reg};
        wy[0] = ONE_Q16 - {1'b0, a_fy_reg};
        wy[1] = {1'b0, a_fy_reg};
        for (int t = 0; t < 4; t++) begin
            b_w_next[t] = WW'(wx[t % 2] * wy[t / 2]);
        end
    end

    logic                  b_vld_reg;
    ctl_t                  b_ctl_reg;
    logic signed [TXW-1:0] b_tx_reg [2];
    logic signed [TXW-1:0] b_ty_reg [2];
    logic [AMW-1:0]        b_amag_reg [2];
    logic [AMW-1:0]        b_bmag_reg [2];
    logic [2*AMW-1:0]      b_asq_reg [2];
    logic [2*AMW-1:0]      b_bsq_reg [2];
    logic [WW-1:0]         b_w_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (adv) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_ctl_reg <= a_ctl_reg;
            for (int i = 0; i < 2; i++) begin
                b_tx_reg[i]   <= b_tx_next[i];
                b_ty_reg[i]   <= b_ty_next[i];
                b_amag_reg[i] <= b_amag_next[i];
                b_bmag_reg[i] <= b_bmag_next[i];
                b_asq_reg[i]  <= b_amag_next[i] * b_amag_next[i];
                b_bsq_reg[i]  <= b_bmag_next[i] * b_bmag_next[i];
            end
            for (int t = 0; t < 4; t++) begin
                b_w_reg[t] <= b_w_next[t];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage C: disk test and fold dividends for each of the four texels.
    // Texel t uses x index t%2 and y index t/2.
    // ---------------------------------------------------------------
    fd_t fd_in [4];

    always_comb begin
        for (int t = 0; t < 4; t++) begin
            fd_in[t].q    = QW'(b_asq_reg[t % 2]) + QW'(b_bsq_reg[t / 2]);
            fd_in[t].fold = fd_in[t].q > QW'(FOLD_LIM);
            fd_in[t].rx   = CW'(b_amag_reg[t % 2]) * CW'(TWO_DD);
            fd_in[t].ry   = CW'(b_bmag_reg[t / 2]) * CW'(TWO_DD);
            fd_in[t].qx   = '0;
            fd_in[t].qy   = '0;
            fd_in[t].sx   = b_tx_reg[t % 2][TXW-1];
            fd_in[t].sy   = b_ty_reg[t / 2][TXW-1];
            fd_in[t].tx   = b_tx_reg[t % 2];
            fd_in[t].ty   = b_ty_reg[t / 2];
            fd_in[t].w    = b_w_reg[t];
        end
    end

    logic fd_vld_reg [FQB+1];
    ctl_t fd_ctl_reg [FQB+1];
    fd_t  fd_reg     [FQB+1][4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fd_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            fd_vld_reg[0] <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fd_ctl_reg[0] <= b_ctl_reg;
            for (int t = 0; t < 4; t++) begin
                fd_reg[0][t] <= fd_in[t];
            end
        end
    end

    // ---------------------------------------------------------------
    // Fold divider stages: 2|a|D^2 / Q, most significant bit first.
    // ---------------------------------------------------------------
    for (genvar k = 0; k < FQB; k++) begin : g_fold
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                fd_vld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                fd_vld_reg[k+1] <= fd_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                fd_ctl_reg[k+1] <= fd_ctl_reg[k];
                for (int t = 0; t < 4; t++) begin
                    fd_reg[k+1][t] <= fd_step(fd_reg[k][t], FQB - 1 - k);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage E: pick folded or direct coordinates and the hemisphere.
    // ---------------------------------------------------------------
    logic [FQB:0]          mx [4];
    logic [FQB:0]          my [4];
    logic signed [TXW-1:0] xf [4];
    logic signed [TXW-1:0] yf [4];
    logic signed [TXW-1:0] e_x_next [4];
    logic signed [TXW-1:0] e_y_next [4];

    always_comb begin
        for (int t = 0; t < 4; t++) begin
            mx[t] = {1'b0, fd_reg[FQB][t].qx}
                  + (FQB+1)'(fd_reg[FQB][t].sx && fd_reg[FQB][t].rx != '0);
            my[t] = {1'b0, fd_reg[FQB][t].qy}
                  + (FQB+1)'(fd_reg[FQB][t].sy && fd_reg[FQB][t].ry != '0);
            xf[t] = TXW'(mx[t]);
            yf[t] = TXW'(my[t]);
            if (fd_reg[FQB][t].fold) begin
                e_x_next[t] = fd_reg[FQB][t].sx ? -xf[t] : xf[t];
                e_y_next[t] = fd_reg[FQB][t].sy ? -yf[t] : yf[t];
            end else begin
                e_x_next[t] = fd_reg[FQB][t].tx;
                e_y_next[t] = fd_reg[FQB][t].ty;
            end
        end
    end

    logic                  e_vld_reg;
    ctl_t                  e_ctl_reg;
    logic signed [TXW-1:0] e_x_reg [4];
    logic signed [TXW-1:0] e_y_reg [4];
    logic                  e_h_reg [4];
    logic [WW-1:0]         e_w_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
        end else if (adv) begin
            e_vld_reg <= fd_vld_reg[FQB];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_ctl_reg <= fd_ctl_reg[FQB];
            for (int t = 0; t < 4; t++) begin
                e_x_reg[t] <= e_x_next[t];
                e_y_reg[t] <= e_y_next[t];
                e_h_reg[t] <= fd_ctl_reg[FQB].up ^ fd_reg[FQB][t].fold;
                e_w_reg[t] <= fd_reg[FQB][t].w;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage F: row and column, clamped into the map, and the address.
    // ---------------------------------------------------------------
    logic signed [RCW-1:0] rowv [4];
    logic signed [RCW-1:0] colv [4];
    logic [RW-1:0]         row  [4];
    logic [RW-1:0]         col  [4];
    logic [IW:0]           f_addr_next [4];

    always_comb begin
        for (int t = 0; t < 4; t++) begin
            rowv[t] = RCW'(D) - RCW'(e_y_reg[t]) - RCW'(1);
            colv[t] = RCW'(e_x_reg[t]) + RCW'(D);
            if (rowv[t] < 0) begin
                row[t] = '0;
            end else if (rowv[t] > RCW'(MAP_SIZE - 1)) begin
                row[t] = RW'(MAP_SIZE - 1);
            end else begin
                row[t] = RW'(rowv[t]);
            end
            if (colv[t] < 0) begin
                col[t] = '0;
            end else if (colv[t] > RCW'(MAP_SIZE - 1)) begin
                col[t] = RW'(MAP_SIZE - 1);
            end else begin
                col[t] = RW'(colv[t]);
            end
            f_addr_next[t] = {e_h_reg[t], IW'(IW'(row[t]) * IW'(MAP_SIZE) + IW'(col[t]))};
        end
    end

    logic          f_vld_reg;
    ctl_t          f_ctl_reg;
    logic [IW:0]   f_addr_reg [4];
    logic [WW-1:0] f_w_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg <= 1'b0;
        end else if (adv) begin
            f_vld_reg <= e_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_ctl_reg <= e_ctl_reg;
            for (int t = 0; t < 4; t++) begin
                f_addr_reg[t] <= f_addr_next[t];
                f_w_reg[t]    <= e_w_reg[t];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage G: texel stores. Both hemispheres share one address space
    // with the hemisphere as top bit. Two copies each serve two reads;
    // writes travel down the pipe so they land in beat order.
    // ---------------------------------------------------------------
    logic               mem_we;
    logic [TEXEL_W-1:0] mem_a [2**(IW+1)];
    logic [TEXEL_W-1:0] mem_b [2**(IW+1)];
    logic [TEXEL_W-1:0] g_rd_reg [4];

    assign mem_we = adv && f_vld_reg && f_ctl_reg.we;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_a[f_ctl_reg.waddr] <= f_ctl_reg.wval;
        end
        if (adv) begin
            g_rd_reg[0] <= mem_a[f_addr_reg[0]];
            g_rd_reg[1] <= mem_a[f_addr_reg[1]];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_b[f_ctl_reg.waddr] <= f_ctl_reg.wval;
        end
        if (adv) begin
            g_rd_reg[2] <= mem_b[f_addr_reg[2]];
            g_rd_reg[3] <= mem_b[f_addr_reg[3]];
        end
    end

    // Write beats end here; only samples continue.
    logic          g_vld_reg;
    logic          g_up_reg;
    logic [WW-1:0] g_w_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_vld_reg <= 1'b0;
        end else if (adv) begin
            g_vld_reg <= f_vld_reg && f_ctl_reg.smp;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g_up_reg <= f_ctl_reg.up;
            for (int t = 0; t < 4; t++) begin
                g_w_reg[t] <= f_w_reg[t];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage H: weight times texel. The weights sum to 2^32, so every
    // partial and total stays below 2^64.
    // ---------------------------------------------------------------
    logic [WW+TEXEL_W-1:0] prod [4];
    logic                  h_vld_reg;
    logic                  h_up_reg;
    logic [63:0]           h_p_reg [4];

    always_comb begin
        for (int t = 0; t < 4; t++) begin
            prod[t] = g_w_reg[t] * g_rd_reg[t];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_vld_reg <= 1'b0;
        end else if (adv) begin
            h_vld_reg <= g_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            h_up_reg <= g_up_reg;
            for (int t = 0; t < 4; t++) begin
                h_p_reg[t] <= 64'(prod[t]);
            end
        end
    end

    // Stage I: pairwise sums.
    logic        i_vld_reg;
    logic        i_up_reg;
    logic [63:0] i_s_reg [2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_vld_reg <= 1'b0;
        end else if (adv) begin
            i_vld_reg <= h_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            i_up_reg   <= h_up_reg;
            i_s_reg[0] <= h_p_reg[0] + h_p_reg[1];
            i_s_reg[1] <= h_p_reg[2] + h_p_reg[3];
        end
    end

    // Final sum, rounded half up from Q.32 to Q.0 at the texel scale.
    logic [63:0]        acc;
    logic [64:0]        rnd;
    logic [TEXEL_W-1:0] flux;
    logic               res_vld;

    always_comb begin
        acc     = i_s_reg[0] + i_s_reg[1];
        rnd     = {1'b0, acc} + ROUND_HALF;
        flux    = rnd[63:32];
        res_vld = adv && i_vld_reg;
    end

    // ---------------------------------------------------------------
    // Output register with a skid entry behind it. The pipeline stalls
    // only while the skid entry is full.
    // ---------------------------------------------------------------
    logic               m_valid_reg;
    logic [TEXEL_W-1:0] m_flux_reg;
    logic               m_up_reg;
    logic [TEXEL_W-1:0] skid_flux_reg;
    logic               skid_up_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= res_vld;
            end
        end else if (res_vld) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_flux_reg <= skid_flux_reg;
                m_up_reg   <= skid_up_reg;
            end else begin
                m_flux_reg <= flux;
                m_up_reg   <= i_up_reg;
            end
        end else if (res_vld) begin
            skid_flux_reg <= flux;
            skid_up_reg   <= i_up_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_flux_reg;
    assign m_tuser  = m_up_reg;

    // ---------------------------------------------------------------
    // Checks on the output buffer.
    // ---------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_tvalid)
        else $error("skid entry full while output register is empty");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_tvalid && !m_tready))
        else $error("skid entry filled without a stalled output");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(skid_valid_reg) |-> m_tvalid)
        else $error("skid entry drained but output register not loaded");

endmodule
